[sv/assert_macros.svh]
// assertion helpers for the rtl folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
	else $error("assertion failed");

// condition that never holds outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
	else $error("forbidden condition seen");

`endif

[sv/gts_pkg.sv]
package gts_pkg;

	// ranking depth and derived widths
	localparam int MAX_BEST = 16;
	localparam int CNT_W    = $clog2(MAX_BEST + 1);
	localparam int WORD_W   = 32;
	localparam int CFG_W    = 5;
	localparam logic [CFG_W-1:0] BEST_RESET = CFG_W'(1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INSERT,
		ST_FLUSH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_item;
		logic do_insert;
		logic start_flush;
		logic shift_out;
		logic close_group;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic key_differs;
		logic eos;
		logic rem_zero;
	} dp_status_t;

endpackage

[sv/gts_in_if.sv]
interface gts_in_if;
	import gts_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] group_word;
	logic [WORD_W-1:0] partner_word;
	logic [WORD_W-1:0] pair_count;
	logic              end_of_stream;

	modport source (
		output valid, group_word, partner_word, pair_count, end_of_stream,
		input  ready
	);
	modport sink (
		input  valid, group_word, partner_word, pair_count, end_of_stream,
		output ready
	);
endinterface

[sv/gts_out_if.sv]
interface gts_out_if;
	import gts_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] out_group_word;
	logic [WORD_W-1:0] out_partner_word;
	logic [WORD_W-1:0] out_pair_count;
	logic              group_done;

	modport source (
		output valid, out_group_word, out_partner_word, out_pair_count, group_done,
		input  ready
	);
	modport sink (
		input  valid, out_group_word, out_partner_word, out_pair_count, group_done,
		output ready
	);
endinterface

[sv/gts_datapath.sv]
module gts_datapath import gts_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic [WORD_W-1:0] in_group_word,
	input  logic [WORD_W-1:0] in_partner_word,
	input  logic [WORD_W-1:0] in_pair_count,
	input  logic              in_end_of_stream,
	input  ctrl_cmd_t         cmd,
	output dp_status_t        status,
	output logic [WORD_W-1:0] out_group_word,
	output logic [WORD_W-1:0] out_partner_word,
	output logic [WORD_W-1:0] out_pair_count,
	output logic              group_done
);

	logic [CFG_W-1:0]  best_q;
	logic [WORD_W-1:0] key_q;
	logic              open_q;
	logic [CNT_W-1:0]  held_q;
	logic [CNT_W-1:0]  rem_q;

	logic [WORD_W-1:0] item_key_s1;
	logic [WORD_W-1:0] item_part_s1;
	logic [WORD_W-1:0] item_cnt_s1;
	logic              item_eos_s1;

	logic [WORD_W-1:0] part_q [MAX_BEST];
	logic [WORD_W-1:0] val_q  [MAX_BEST];

	logic [MAX_BEST-1:0] ge;
	logic [CNT_W-1:0]    held_nxt;
	logic [CNT_W-1:0]    limit;
	logic [CNT_W-1:0]    flush_n;

	// entries that stay ahead of the new record (sorted, so a prefix)
	always_comb begin
		for (int i = 0; i < MAX_BEST; i++) begin
			ge[i] = (CNT_W'(i) < held_q) && (val_q[i] >= item_cnt_s1);
		end
	end

	// held count after this cycle, used for the flush length
	always_comb begin
		held_nxt = held_q;
		if (cmd.do_insert && (32'(held_q) < 32'(MAX_BEST))) begin
			held_nxt = held_q + CNT_W'(1);
		end
	end

	// emitted length: min(held, saturated best_count)
	always_comb begin
		if (32'(best_q) > 32'(MAX_BEST)) begin
			limit = CNT_W'(MAX_BEST);
		end else begin
			limit = CNT_W'(best_q);
		end
		flush_n = (held_nxt < limit) ? held_nxt : limit;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= BEST_RESET;
			key_q  <= '0;
			open_q <= 1'b0;
			held_q <= '0;
			rem_q  <= '0;
		end else begin
			if (cfg_we) begin
				best_q <= cfg_wdata;
			end
			if (cmd.do_insert) begin
				held_q <= held_nxt;
				if (!open_q) begin
					open_q <= 1'b1;
					key_q  <= item_key_s1;
				end
			end
			if (cmd.start_flush) begin
				rem_q <= flush_n;
			end else if (cmd.shift_out) begin
				rem_q <= rem_q - CNT_W'(1);
			end
			if (cmd.close_group) begin
				open_q <= 1'b0;
				held_q <= '0;
			end
		end
	end

	// item capture and ranking storage
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_key_s1  <= in_group_word;
			item_part_s1 <= in_partner_word;
			item_cnt_s1  <= in_pair_count;
			item_eos_s1  <= in_end_of_stream;
		end
		if (cmd.do_insert) begin
			for (int i = 0; i < MAX_BEST; i++) begin
				if (!ge[i]) begin
					if (i == 0 || ge[(i == 0) ? 0 : i - 1]) begin
						part_q[i] <= item_part_s1;
						val_q[i]  <= item_cnt_s1;
					end else begin
						part_q[i] <= part_q[(i == 0) ? 0 : i - 1];
						val_q[i]  <= val_q[(i == 0) ? 0 : i - 1];
					end
				end
			end
		end else if (cmd.shift_out) begin
			for (int i = 0; i < MAX_BEST - 1; i++) begin
				part_q[i] <= part_q[i + 1];
				val_q[i]  <= val_q[i + 1];
			end
		end
	end

	// status, group key and output payload from the head entry
	assign status.key_differs = open_q && (item_key_s1 != key_q);
	assign status.eos         = item_eos_s1;
	assign status.rem_zero    = (rem_q == '0);

	assign out_group_word   = key_q;
	assign out_partner_word = part_q[0];
	assign out_pair_count   = val_q[0];
	assign group_done       = (rem_q == CNT_W'(1));

endmodule

[sv/gts_ctrl.sv]
module gts_ctrl import gts_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;
	logic   ret_insert_q;
	logic   ret_insert_d;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_INSERT;
				end
			end
			ST_INSERT: begin
				if (status.key_differs || status.eos) begin
					state_d = ST_FLUSH;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (status.rem_zero) begin
					state_d = ret_insert_q ? ST_INSERT : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// commands and handshake
	always_comb begin
		cmd          = '0;
		in_ready     = 1'b0;
		out_valid    = 1'b0;
		ret_insert_d = ret_insert_q;
		case (state_q)
			ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.load_item = in_valid;
			end
			ST_INSERT: begin
				if (status.key_differs) begin
					// old group goes out before the record is ranked
					cmd.start_flush = 1'b1;
					ret_insert_d    = 1'b1;
				end else begin
					cmd.do_insert = 1'b1;
					if (status.eos) begin
						cmd.start_flush = 1'b1;
						ret_insert_d    = 1'b0;
					end
				end
			end
			ST_FLUSH: begin
				if (status.rem_zero) begin
					cmd.close_group = 1'b1;
				end else begin
					out_valid     = 1'b1;
					cmd.shift_out = out_ready;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ret_insert_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			ret_insert_q <= ret_insert_d;
		end
	end

endmodule

[sv/grouped_top_n_select.sv]
// when no group ends, a record is transferred in ST_IDLE and ranked in ST_INSERT
// the ranking cycle compares against all held entries in parallel and shifts in place
// a group end adds a flush of the held records (output stalls hold it), then a group close
// a key change also returns to ranking for the new record after the flush
// the flush is started in ST_INSERT and its first result offered in ST_FLUSH
// arst_n clears the group, held count and controller; best_count returns to 1
`include "assert_macros.svh"

module grouped_top_n_select import gts_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	gts_in_if.sink           in_ch,
	gts_out_if.source        out_ch
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	gts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	gts_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.in_group_word    (in_ch.group_word),
		.in_partner_word  (in_ch.partner_word),
		.in_pair_count    (in_ch.pair_count),
		.in_end_of_stream (in_ch.end_of_stream),
		.cmd              (cmd),
		.status           (status),
		.out_group_word   (out_ch.out_group_word),
		.out_partner_word (out_ch.out_partner_word),
		.out_pair_count   (out_ch.out_pair_count),
		.group_done       (out_ch.group_done)
	);

	// checks
	`ASSERT_NEVER(a_no_take_while_flush, clk, arst_n, in_ch.ready && out_ch.valid)
	`ASSERT_CLK(a_done_ends_group, clk, arst_n, (out_ch.valid && out_ch.ready && out_ch.group_done) |=> !out_ch.valid)
	`ASSERT_NEVER(a_flush_not_idle, clk, arst_n, cmd.start_flush && in_ch.ready)
	`ASSERT_NEVER(a_insert_or_shift, clk, arst_n, cmd.do_insert && cmd.shift_out)

endmodule
